// ----- rtl/plbct_pkg.sv -----
package plbct_pkg;

  localparam int BLOCK_W    = 12;
  localparam int DISK_W     = 13;
  localparam int SLOT_W     = 4;
  localparam int STAMP_W    = 32;
  localparam int ENTRIES_DEF = 16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PAST_END = 2'd1,
    ST_FULL     = 2'd2,
    ST_PINNED   = 2'd3
  } status_e;

  typedef struct packed {
    logic [BLOCK_W-1:0] tag;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/plbct_ram.sv -----
module plbct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pinned_lru_block_cache_tags.sv -----
// Channel  Direction  Handshake                Payload
// in       request    in_valid_i / in_stall_o  mode_i, block_number_i, release_slot_i
// out      result     out_valid_o / out_stall_i slot_o, hit_o, writeback_o,
//                                               victim_block_o, status_o
// cfg      write      cfg_we_i                 cfg_wdata_i (disk_blocks)
//
// From acceptance to the result register, a get steps through: a check of the disk
// bound, one read of the tag/stamp memory per entry (each read registered in the
// memory), a step to settle the choice, and a commit. A release or an out-of-range
// get skips the reads and goes straight to the commit.
// The single read port of the entry memory paces the scan; one request is in work at a time.
// Reset clears the valid and pinned bits, the use clock and disk_blocks; the memory
// itself is not cleared, since an entry that is not valid reads as tag 0 and stamp 0.
// A stalled output holds the finished beat in the commit state, and no state is updated
// until that beat moves into the output register.
module pinned_lru_block_cache_tags
  import plbct_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [DISK_W-1:0]  cfg_wdata_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [BLOCK_W-1:0] block_number_i,
  input  logic [SLOT_W-1:0]  release_slot_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SLOT_W-1:0]  slot_o,
  output logic               hit_o,
  output logic               writeback_o,
  output logic [BLOCK_W-1:0] victim_block_o,
  output logic [1:0]         status_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int RW = ((IW > SLOT_W) ? IW : SLOT_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_START  = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [DISK_W-1:0]  disk_blocks_q;
  logic [STAMP_W-1:0] use_clock_q;
  logic [ENTRIES-1:0] valid_q;
  logic [ENTRIES-1:0] pinned_q;

  // Request being worked on.
  logic               item_mode_q;
  logic [BLOCK_W-1:0] item_bno_q;
  logic [SLOT_W-1:0]  item_rel_q;

  // Scan bookkeeping.
  logic [CW-1:0]      rd_cnt_q;
  logic               cmp_vld_q;
  logic [IW-1:0]      cmp_idx_q;
  logic               found_q;
  logic [IW-1:0]      found_idx_q;
  logic               least_vld_q;
  logic [IW-1:0]      least_idx_q;
  logic [STAMP_W-1:0] least_stamp_q;
  logic [BLOCK_W-1:0] least_tag_q;
  logic               least_wb_q;

  // Finished result and the update it carries.
  logic [SLOT_W-1:0]  res_slot_q;
  logic               res_hit_q;
  logic               res_wb_q;
  logic [BLOCK_W-1:0] res_victim_q;
  status_e            res_status_q;
  logic               upd_grant_q;
  logic               upd_release_q;
  logic [IW-1:0]      upd_idx_q;
  logic [BLOCK_W-1:0] upd_tag_q;

  // Output register.
  logic               out_valid_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic               out_hit_q;
  logic               out_wb_q;
  logic [BLOCK_W-1:0] out_victim_q;
  status_e            out_status_q;

  // Memory ports.
  logic               ram_re;
  logic               ram_we;
  entry_t             ram_wdata;
  entry_t             ram_rdata;
  entry_t             cmp_entry;
  logic               cmp_valid;
  logic               cmp_pinned;

  // Decode.
  logic               in_accept;
  logic               commit;
  logic               past_end;
  logic [RW-1:0]      rel_ext;
  logic               rel_in_range;
  logic               scan_done;
  status_e            dec_status;
  logic               dec_grant;
  logic [IW-1:0]      dec_idx;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign commit     = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);

  assign past_end     = ({1'b0, item_bno_q} >= disk_blocks_q);
  assign rel_ext      = RW'(item_rel_q);
  assign rel_in_range = (rel_ext < RW'(ENTRIES));

  assign ram_re    = (state_q == S_SCAN) && (rd_cnt_q < CW'(ENTRIES));
  assign ram_we    = commit && upd_grant_q;
  assign ram_wdata = '{tag: upd_tag_q, stamp: use_clock_q + 1'b1};

  // An entry that was never filled reads as tag 0 and stamp 0.
  assign cmp_valid  = valid_q[cmp_idx_q];
  assign cmp_pinned = pinned_q[cmp_idx_q];
  assign cmp_entry  = cmp_valid ? ram_rdata : '0;

  assign scan_done = (state_q == S_SCAN) && (rd_cnt_q == CW'(ENTRIES)) && !cmp_vld_q;

  always_comb begin
    if (found_q) begin
      dec_status = pinned_q[found_idx_q] ? ST_PINNED : ST_OK;
      dec_idx    = found_idx_q;
    end else begin
      dec_status = least_vld_q ? ST_OK : ST_FULL;
      dec_idx    = least_idx_q;
    end
    dec_grant = (dec_status == ST_OK);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_START;
      end
      S_START: begin
        state_d = (item_mode_q || past_end) ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  plbct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (upd_idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_cnt_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      disk_blocks_q <= '0;
      use_clock_q   <= '0;
      valid_q       <= '0;
      pinned_q      <= '0;
      rd_cnt_q      <= '0;
      cmp_vld_q     <= 1'b0;
      found_q       <= 1'b0;
      least_vld_q   <= 1'b0;
      upd_grant_q   <= 1'b0;
      upd_release_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        disk_blocks_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_START: begin
          rd_cnt_q      <= '0;
          cmp_vld_q     <= 1'b0;
          found_q       <= 1'b0;
          least_vld_q   <= 1'b0;
          upd_grant_q   <= 1'b0;
          upd_release_q <= item_mode_q && rel_in_range;
        end
        S_SCAN: begin
          cmp_vld_q <= ram_re;
          if (ram_re) begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end
          if (cmp_vld_q) begin
            if (!found_q && cmp_valid && (cmp_entry.tag == item_bno_q)) begin
              found_q <= 1'b1;
            end
            if (!cmp_pinned && (!least_vld_q || (cmp_entry.stamp < least_stamp_q))) begin
              least_vld_q <= 1'b1;
            end
          end
          if (scan_done) begin
            upd_grant_q <= dec_grant;
          end
        end
        S_FINISH: begin
          if (commit) begin
            if (upd_grant_q) begin
              use_clock_q          <= use_clock_q + 1'b1;
              valid_q[upd_idx_q]   <= 1'b1;
              pinned_q[upd_idx_q]  <= 1'b1;
            end
            if (upd_release_q) begin
              pinned_q[upd_idx_q] <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_mode_q <= mode_i;
      item_bno_q  <= block_number_i;
      item_rel_q  <= release_slot_i;
    end
    unique case (state_q)
      S_START: begin
        res_slot_q   <= item_mode_q ? item_rel_q : '0;
        res_hit_q    <= 1'b0;
        res_wb_q     <= 1'b0;
        res_victim_q <= '0;
        res_status_q <= item_mode_q ? ST_OK : ST_PAST_END;
        upd_idx_q    <= rel_ext[IW-1:0];
      end
      S_SCAN: begin
        cmp_idx_q <= rd_cnt_q[IW-1:0];
        if (cmp_vld_q) begin
          if (!found_q && cmp_valid && (cmp_entry.tag == item_bno_q)) begin
            found_idx_q <= cmp_idx_q;
          end
          if (!cmp_pinned && (!least_vld_q || (cmp_entry.stamp < least_stamp_q))) begin
            least_idx_q   <= cmp_idx_q;
            least_stamp_q <= cmp_entry.stamp;
            least_tag_q   <= cmp_entry.tag;
            least_wb_q    <= cmp_valid;
          end
        end
        if (scan_done) begin
          res_slot_q   <= dec_grant ? SLOT_W'(dec_idx) : '0;
          res_hit_q    <= dec_grant && found_q;
          res_wb_q     <= dec_grant && !found_q && least_wb_q;
          res_victim_q <= (dec_grant && !found_q && least_wb_q) ? least_tag_q : '0;
          res_status_q <= dec_status;
          upd_idx_q    <= dec_idx;
          upd_tag_q    <= item_bno_q;
        end
      end
      default: begin
      end
    endcase
    if (commit) begin
      out_slot_q   <= res_slot_q;
      out_hit_q    <= res_hit_q;
      out_wb_q     <= res_wb_q;
      out_victim_q <= res_victim_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign slot_o         = out_slot_q;
  assign hit_o          = out_hit_q;
  assign writeback_o    = out_wb_q;
  assign victim_block_o = out_victim_q;
  assign status_o       = out_status_q;

`ifndef NO_ASSERTIONS
  // A granted slot is pinned and valid right after the commit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && upd_grant_q) |=> (pinned_q[$past(upd_idx_q)] && valid_q[$past(upd_idx_q)]))
    else $error("granted slot not pinned after commit");

  // The use clock only advances when a get is granted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (use_clock_q != $past(use_clock_q)) |-> $past(commit && upd_grant_q))
    else $error("use clock advanced without a grant");

  // A new result beat is only loaded from the commit state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result beat appeared outside commit");

  // A hit never reports a write-back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_hit_q) |-> (!out_wb_q && (out_status_q == ST_OK)))
    else $error("hit reported with write-back or error");
`endif

endmodule
